// File: src/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: src/cit_pkg.sv
package cit_pkg;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CLEAR, S_HIST, S_PREFIX, S_SCAT, S_DONE
    } t_state;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ROFF  = 2'd1;
    localparam logic [1:0] REQ_ENTRY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_NB    = 2'd3;

    localparam logic CFG_NUM_POINTS = 1'b0;
    localparam logic CFG_NUM_CELLS  = 1'b1;

endpackage

// File: src/cit_ram.sv
module cit_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/csr_incidence_transpose.sv
// Transposes a cell-to-node incidence list into node-to-cell rows.
// Slave stream: tdata = cell_id, node_id, read_index; tuser = req_type;
// tlast = last_pair. Master stream: tdata = value; tuser = status.
// A load beat without tlast is taken and gives no result.
// A read beat reads the offset or row memory as it is taken, and the
// result goes to the output register on the next cycle, in S_READ.
// A load beat with tlast starts the build: a clearing sweep over all
// entries of the offset and row memories, a histogram over the stored
// pairs, a prefix sum over the node slots (MAX_POINTS), a scatter of
// the pairs into the rows, then a step that posts the total count.
// No beat is taken meanwhile.
// The output register holds a result until the master side takes it; a new
// beat is taken only when that register is empty or being drained.
// Reset clears the control state, the flags and the pair count; the memories
// need no reset. The config port is to be written by the user only while idle; the block does not enforce it.
`include "assert_macros.svh"

module csr_incidence_transpose #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_PAIRS  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cell_id, node_id, read_index, zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int PW  = $clog2(MAX_PAIRS);
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int OW  = $clog2(MAX_POINTS + 1);
    localparam int CAW = $clog2(MAX_POINTS);
    localparam int SL  = (MAX_PAIRS > MAX_POINTS + 1) ? MAX_PAIRS : MAX_POINTS + 1;
    localparam int SW  = $clog2(SL + 1);

    cit_pkg::t_state r_state, n_state;
    logic [10:0]   r_num_points;
    logic [15:0]   r_num_cells;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_built, n_built;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_acc, n_acc;
    logic [SW-1:0] r_idx, n_idx;
    logic [1:0]    r_ph, n_ph;
    logic          r_hit, n_hit;
    logic [CAW-1:0] r_node, n_node;
    logic [15:0]   r_cell, n_cell;
    logic          r_rkind, n_rkind;
    logic          r_rok, n_rok;
    logic [1:0]    r_rstat, n_rstat;
    logic          r_ov, n_ov;
    logic [15:0]   r_odata, n_odata;
    logic [1:0]    r_ostat, n_ostat;

    logic          pair_we, offs_we, curs_we, rows_we;
    logic [PW-1:0] pair_wa, pair_ra, rows_wa, rows_ra;
    logic [31:0]   pair_wd, pair_rd;
    logic [OW-1:0] offs_wa, offs_ra;
    logic [CW-1:0] offs_wd, offs_rd, curs_wd, curs_rd;
    logic [CAW-1:0] curs_wa, curs_ra;
    logic [15:0]   rows_wd, rows_rd;

    logic [31:0]   np32, idx32, pnode32;
    logic [15:0]   pcell, in_cell, in_node;
    logic [12:0]   in_idx;
    logic          node_ok, accept, draining;
    logic [CW-1:0] eff_cnt;

    cit_ram #(.DEPTH(MAX_PAIRS), .WIDTH(32)) u_pairs (
        .i_clk(i_clk), .i_we(pair_we), .i_waddr(pair_wa), .i_wdata(pair_wd),
        .i_raddr(pair_ra), .o_rdata(pair_rd)
    );
    cit_ram #(.DEPTH(MAX_POINTS + 1), .WIDTH(CW)) u_offs (
        .i_clk(i_clk), .i_we(offs_we), .i_waddr(offs_wa), .i_wdata(offs_wd),
        .i_raddr(offs_ra), .o_rdata(offs_rd)
    );
    cit_ram #(.DEPTH(MAX_POINTS), .WIDTH(CW)) u_curs (
        .i_clk(i_clk), .i_we(curs_we), .i_waddr(curs_wa), .i_wdata(curs_wd),
        .i_raddr(curs_ra), .o_rdata(curs_rd)
    );
    cit_ram #(.DEPTH(MAX_PAIRS), .WIDTH(16)) u_rows (
        .i_clk(i_clk), .i_we(rows_we), .i_waddr(rows_wa), .i_wdata(rows_wd),
        .i_raddr(rows_ra), .o_rdata(rows_rd)
    );

    assign in_cell = s_axis_tdata[15:0];
    assign in_node = s_axis_tdata[31:16];
    assign in_idx  = s_axis_tdata[44:32];
    assign idx32   = 32'(in_idx);
    assign np32    = (32'(r_num_points) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS)
                                                           : 32'(r_num_points);
    assign pnode32 = 32'(pair_rd[31:16]);
    assign pcell   = pair_rd[15:0];
    assign node_ok = !pair_rd[31] && (pnode32 < np32);
    assign draining = r_ov && m_axis_tready;
    assign s_axis_tready = (r_state == cit_pkg::S_IDLE) && (!r_ov || m_axis_tready);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign eff_cnt = r_built ? '0 : r_cnt;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cit_pkg::S_IDLE;
            r_num_points <= 11'd1024;
            r_num_cells  <= 16'hFFFF;
            r_cnt        <= '0;
            r_built      <= 1'b0;
            r_ovf        <= 1'b0;
            r_ov         <= 1'b0;
            r_ph         <= '0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_built <= n_built;
            r_ovf   <= n_ovf;
            r_ov    <= n_ov;
            r_ph    <= n_ph;
            r_idx   <= n_idx;
            if (i_cfg_we && i_cfg_idx == cit_pkg::CFG_NUM_POINTS) begin
                r_num_points <= i_cfg_data[10:0];
            end
            if (i_cfg_we && i_cfg_idx == cit_pkg::CFG_NUM_CELLS) begin
                r_num_cells <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_acc   <= n_acc;
        r_hit   <= n_hit;
        r_node  <= n_node;
        r_cell  <= n_cell;
        r_rkind <= n_rkind;
        r_rok   <= n_rok;
        r_rstat <= n_rstat;
        r_odata <= n_odata;
        r_ostat <= n_ostat;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_built = r_built;
        n_ovf   = r_ovf;
        n_total = r_total;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_ph    = r_ph;
        n_hit   = r_hit;
        n_node  = r_node;
        n_cell  = r_cell;
        n_rkind = r_rkind;
        n_rok   = r_rok;
        n_rstat = r_rstat;
        n_ov    = draining ? 1'b0 : r_ov;
        n_odata = r_odata;
        n_ostat = r_ostat;
        pair_we = 1'b0;
        pair_wa = eff_cnt[PW-1:0];
        pair_wd = {in_node, in_cell};
        pair_ra = r_idx[PW-1:0];
        offs_we = 1'b0;
        offs_wa = r_idx[OW-1:0];
        offs_wd = '0;
        offs_ra = OW'(in_idx);
        curs_we = 1'b0;
        curs_wa = r_node;
        curs_wd = '0;
        curs_ra = CAW'(pnode32);
        rows_we = 1'b0;
        rows_wa = r_idx[PW-1:0];
        rows_wd = '0;
        rows_ra = PW'(in_idx);

        unique case (r_state) inside
            cit_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_axis_tuser) inside
                        cit_pkg::REQ_LOAD: begin
                            n_built = 1'b0;
                            n_ovf   = r_built ? 1'b0 : r_ovf;
                            if (32'(eff_cnt) < 32'(MAX_PAIRS)) begin
                                pair_we = 1'b1;
                                n_cnt   = CW'(eff_cnt + 1'b1);
                            end else begin
                                n_cnt = eff_cnt;
                                n_ovf = 1'b1;
                            end
                            if (s_axis_tlast) begin
                                n_state = cit_pkg::S_CLEAR;
                                n_idx   = '0;
                            end
                        end
                        cit_pkg::REQ_ROFF, cit_pkg::REQ_ENTRY: begin
                            n_state = cit_pkg::S_READ;
                            n_rkind = (s_axis_tuser == cit_pkg::REQ_ROFF);
                            n_rok   = 1'b0;
                            if (!r_built) begin
                                n_rstat = cit_pkg::ST_NB;
                            end else if (s_axis_tuser == cit_pkg::REQ_ROFF) begin
                                n_rok   = (idx32 <= np32);
                                n_rstat = n_rok ? (r_ovf ? cit_pkg::ST_OVF : cit_pkg::ST_OK)
                                                : cit_pkg::ST_RANGE;
                            end else begin
                                n_rok   = (idx32 < 32'(r_total)) && (idx32 < 32'(MAX_PAIRS));
                                n_rstat = n_rok ? (r_ovf ? cit_pkg::ST_OVF : cit_pkg::ST_OK)
                                                : cit_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cit_pkg::S_READ: begin
                n_ov    = 1'b1;
                n_ostat = r_rstat;
                n_odata = !r_rok ? 16'd0 : (r_rkind ? 16'(offs_rd) : rows_rd);
                n_state = cit_pkg::S_IDLE;
            end
            cit_pkg::S_CLEAR: begin
                offs_we = (32'(r_idx) < 32'(MAX_POINTS + 1));
                rows_we = (32'(r_idx) < 32'(MAX_PAIRS));
                n_idx   = SW'(r_idx + 1'b1);
                if (32'(r_idx) == 32'(SL - 1)) begin
                    n_state = cit_pkg::S_HIST;
                    n_idx   = '0;
                    n_ph    = '0;
                end
            end
            cit_pkg::S_HIST, cit_pkg::S_SCAT: begin
                case (r_ph)
                    2'd0: begin
                        if (r_idx == SW'(r_cnt)) begin
                            n_idx = '0;
                            n_acc = '0;
                            n_state = (r_state == cit_pkg::S_HIST) ? cit_pkg::S_PREFIX
                                                                   : cit_pkg::S_DONE;
                        end else begin
                            n_ph = 2'd1;
                        end
                    end
                    2'd1: begin
                        n_node  = CAW'(pnode32);
                        n_cell  = pcell;
                        offs_ra = OW'(pnode32 + 32'd1);
                        n_hit   = node_ok;
                        if (r_state == cit_pkg::S_SCAT) begin
                            n_hit = node_ok && (pcell < r_num_cells);
                        end
                        n_ph = 2'd2;
                    end
                    default: begin
                        if (r_state == cit_pkg::S_HIST) begin
                            offs_we = r_hit;
                            offs_wa = OW'(32'(r_node) + 32'd1);
                            offs_wd = CW'(offs_rd + 1'b1);
                        end else begin
                            rows_we = r_hit && (32'(curs_rd) < 32'(MAX_PAIRS));
                            rows_wa = PW'(curs_rd);
                            rows_wd = r_cell;
                            curs_we = r_hit;
                            curs_wd = CW'(curs_rd + 1'b1);
                        end
                        n_idx = SW'(r_idx + 1'b1);
                        n_ph  = 2'd0;
                    end
                endcase
            end
            cit_pkg::S_PREFIX: begin
                offs_ra = OW'(r_idx + 1'b1);
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    offs_we = 1'b1;
                    offs_wa = OW'(r_idx + 1'b1);
                    offs_wd = CW'(r_acc + offs_rd);
                    curs_we = 1'b1;
                    curs_wa = r_idx[CAW-1:0];
                    curs_wd = r_acc;
                    n_acc   = CW'(r_acc + offs_rd);
                    n_ph    = 2'd0;
                    n_idx   = SW'(r_idx + 1'b1);
                    if (32'(r_idx) == 32'(MAX_POINTS - 1)) begin
                        n_state = cit_pkg::S_SCAT;
                        n_idx   = '0;
                        n_total = CW'(r_acc + offs_rd);
                    end
                end
            end
            cit_pkg::S_DONE: begin
                n_built = 1'b1;
                n_ov    = 1'b1;
                n_odata = 16'(r_total);
                n_ostat = r_ovf ? cit_pkg::ST_OVF : cit_pkg::ST_OK;
                n_state = cit_pkg::S_IDLE;
            end
            default: begin
                n_state = cit_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == cit_pkg::S_IDLE)
    `ASSERT_NEXT(a_read_result, i_clk, i_rst_n, r_state == cit_pkg::S_READ, m_axis_tvalid)
    `ASSERT_NEXT(a_done_built, i_clk, i_rst_n, r_state == cit_pkg::S_DONE, r_built && m_axis_tvalid)
    `ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, 32'(r_cnt) <= 32'(MAX_PAIRS))

endmodule
